### src/rbnh_pkg.sv
// shared constants, types and register codes for the ray / box nearest-hit block
package rbnh_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ID_BITS    = 16;
  localparam int UNIT_FRAC  = 30;

  localparam int DIFF_W = COORD_BITS + 1;            // end - start, box - start
  localparam int LEN_W  = COORD_BITS + 2;            // distances, saturation level
  localparam int SUM_W  = 2 * DIFF_W;                // sum of squared differences
  localparam int T_W    = COORD_BITS + 3;            // signed slab distance
  localparam int UNIT_W = UNIT_FRAC + 1;             // unit direction magnitude
  localparam int INV_W  = UNIT_FRAC + FRAC_BITS + 1; // inverse direction magnitude

  localparam int STEPS_MAX = (INV_W > DIFF_W) ? ((INV_W > UNIT_W) ? INV_W : UNIT_W)
                                              : ((DIFF_W > UNIT_W) ? DIFF_W : UNIT_W);
  localparam int CNT_W = $clog2(STEPS_MAX);

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // per-query ray context produced by the setup sequencer
  typedef struct packed {
    logic [DIFF_W-1:0]            len;
    logic [2:0][UNIT_W-1:0]       unit_mag;
    logic [2:0]                   unit_neg;
    logic [2:0][INV_W-1:0]        inv_mag;
    logic [2:0]                   inv_neg;
    logic                         seg_ok;
  } setup_t;

endpackage

### src/rbnh_setup.sv
// ray setup sequencer: segment length, unit direction and inverse direction
module rbnh_setup (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      restart_i,
  input  logic [2:0][rbnh_pkg::COORD_BITS-1:0]      start_i,
  input  logic [2:0][rbnh_pkg::COORD_BITS-1:0]      end_i,
  output logic                                      done_o,
  output rbnh_pkg::setup_t                          res_o
);

  localparam int CB   = rbnh_pkg::COORD_BITS;
  localparam int DW   = rbnh_pkg::DIFF_W;
  localparam int LW   = rbnh_pkg::LEN_W;
  localparam int SW   = rbnh_pkg::SUM_W;
  localparam int UW   = rbnh_pkg::UNIT_W;
  localparam int IW   = rbnh_pkg::INV_W;
  localparam int CW   = rbnh_pkg::CNT_W;
  localparam int RMW  = DW + 3;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_SQ   = 6'b000010,
    ST_ROOT = 6'b000100,
    ST_UNIT = 6'b001000,
    ST_INV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic [DW-1:0]   mag_q [3];
  logic [2:0]      neg_q;
  logic [DW-1:0]   mplier_q [3];
  logic [SW-1:0]   mcand_q [3];
  logic [SW-1:0]   sum_q, sum_d;
  logic [SW-1:0]   rad_q;
  logic [RMW-1:0]  rem_q, rem_d;
  logic [DW-1:0]   root_q, root_d;
  logic [LW-1:0]   ur_q [3], ur_d [3];
  logic [UW-1:0]   uq_q [3], uq_d [3];
  logic [UW-1:0]   ir_q [3], ir_d [3];
  logic [IW-1:0]   iq_q [3], iq_d [3];

  logic signed [DW-1:0] mv [3];
  logic [DW-1:0]        mv_mag [3];

  // operand prep and one step of each iteration
  always_comb begin
    logic [SW-1:0]  add;
    logic [RMW-1:0] rem_sh, trial;
    logic [LW-1:0]  urn;
    logic           uge, ige;
    logic [UW:0]    rs, irn;
    add = '0;
    for (int i = 0; i < 3; i++) begin
      mv[i] = $signed({start_i[i][CB-1], start_i[i]});
      mv[i] = $signed({end_i[i][CB-1], end_i[i]}) - mv[i];
      mv_mag[i] = mv[i][DW-1] ? DW'(-mv[i]) : DW'(mv[i]);
      add = add + (mplier_q[i][0] ? mcand_q[i] : '0);
    end
    sum_d = sum_q + add;

    // digit-by-digit square root, two radicand bits a step
    rem_sh = {rem_q[RMW-3:0], rad_q[SW-1:SW-2]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[DW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[DW-2:0], 1'b0};
    end

    for (int i = 0; i < 3; i++) begin
      // |move| / len, one quotient bit a step
      uge    = (ur_q[i] >= {1'b0, root_q}) && (root_q != '0);
      urn    = uge ? (ur_q[i] - {1'b0, root_q}) : ur_q[i];
      ur_d[i] = {urn[LW-2:0], 1'b0};
      uq_d[i] = {uq_q[i][UW-2:0], uge};
      // 2^(unit_frac+frac) / unit, dividend has only its top bit set
      rs     = {ir_q[i], (cnt_q == '0)};
      ige    = rs >= {1'b0, uq_q[i]};
      irn    = ige ? (rs - {1'b0, uq_q[i]}) : rs;
      ir_d[i] = irn[UW-1:0];
      iq_d[i] = {iq_q[i][IW-2:0], ige};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        state_d = ST_SQ;
        cnt_d   = '0;
      end
      ST_SQ: if (cnt_q == CW'(DW - 1)) begin
        state_d = ST_ROOT;
        cnt_d   = '0;
      end
      ST_ROOT: if (cnt_q == CW'(DW - 1)) begin
        state_d = ST_UNIT;
        cnt_d   = '0;
      end
      ST_UNIT: if (cnt_q == CW'(UW - 1)) begin
        state_d = ST_INV;
        cnt_d   = '0;
      end
      ST_INV: if (cnt_q == CW'(IW - 1)) begin
        state_d = ST_DONE;
        cnt_d   = '0;
      end
      ST_DONE: cnt_d = cnt_q;
      default: begin
        state_d = ST_LOAD;
        cnt_d   = '0;
      end
    endcase
    if (restart_i) begin
      state_d = ST_LOAD;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i]    <= mv_mag[i];
          neg_q[i]    <= mv[i][DW-1];
          mplier_q[i] <= mv_mag[i];
          mcand_q[i]  <= SW'(mv_mag[i]);
        end
        sum_q <= '0;
      end
      ST_SQ: begin
        sum_q <= sum_d;
        for (int i = 0; i < 3; i++) begin
          mplier_q[i] <= mplier_q[i] >> 1;
          mcand_q[i]  <= mcand_q[i] << 1;
        end
        rad_q  <= sum_d;
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_ROOT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= rem_d;
        root_q <= root_d;
        for (int i = 0; i < 3; i++) begin
          ur_q[i] <= {1'b0, mag_q[i]};
          uq_q[i] <= '0;
        end
      end
      ST_UNIT: begin
        for (int i = 0; i < 3; i++) begin
          ur_q[i] <= ur_d[i];
          uq_q[i] <= uq_d[i];
          ir_q[i] <= '0;
          iq_q[i] <= '0;
        end
      end
      ST_INV: begin
        for (int i = 0; i < 3; i++) begin
          ir_q[i] <= ir_d[i];
          iq_q[i] <= iq_d[i];
        end
      end
      default: ;
    endcase
  end

  // a zero unit component leaves the quotient all ones, which is the saturated inverse
  always_comb begin
    res_o.len    = root_q;
    res_o.seg_ok = (sum_q != '0);
    for (int i = 0; i < 3; i++) begin
      res_o.unit_mag[i] = uq_q[i];
      res_o.unit_neg[i] = neg_q[i];
      res_o.inv_mag[i]  = iq_q[i];
      res_o.inv_neg[i]  = neg_q[i] && (uq_q[i] != '0);
    end
  end

  assign done_o = (state_q == ST_DONE);

endmodule

### src/ray_box_nearest_hit.sv
// top level: nearest ray segment / axis-aligned box hit, q16.16 fixed point
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  cfg     | in        | cfg_we_i            | cfg_idx_i, cfg_wdata_i (ray start / end)
//  box     | in        | in_valid_i/ready_o  | box min/max corners, id, eligible, last_box
//  result  | out       | out_valid_o/ready_i | hit flag, distance, id, normal, hit point
//
// seven pipeline stages plus the output register; one box item a cycle inside a query
//   unless stalled; a query's first item waits until the pipeline has drained, longer
//   while the previous last item is stalled at the final stage
// after reset or a register write the setup sequencer steps through load, squaring,
//   square root, unit direction and inverse direction before a query may start
// the pipeline stalls only when a last item reaches the final stage while a result
//   still waits in the output register
module ray_box_nearest_hit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rbnh_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rbnh_pkg::COORD_BITS-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [rbnh_pkg::COORD_BITS-1:0] box_min_x_i,
  input  logic signed [rbnh_pkg::COORD_BITS-1:0] box_min_y_i,
  input  logic signed [rbnh_pkg::COORD_BITS-1:0] box_min_z_i,
  input  logic signed [rbnh_pkg::COORD_BITS-1:0] box_max_x_i,
  input  logic signed [rbnh_pkg::COORD_BITS-1:0] box_max_y_i,
  input  logic signed [rbnh_pkg::COORD_BITS-1:0] box_max_z_i,
  input  logic [rbnh_pkg::ID_BITS-1:0]          box_id_i,
  input  logic                                  eligible_i,
  input  logic                                  last_box_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  hit_found_o,
  output logic [rbnh_pkg::COORD_BITS:0]         hit_distance_o,
  output logic [rbnh_pkg::ID_BITS-1:0]          hit_box_id_o,
  output logic [1:0]                            normal_axis_o,
  output logic                                  normal_negative_o,
  output logic signed [rbnh_pkg::COORD_BITS-1:0] hit_point_x_o,
  output logic signed [rbnh_pkg::COORD_BITS-1:0] hit_point_y_o,
  output logic signed [rbnh_pkg::COORD_BITS-1:0] hit_point_z_o
);

  localparam int CB  = rbnh_pkg::COORD_BITS;
  localparam int FB  = rbnh_pkg::FRAC_BITS;
  localparam int IDB = rbnh_pkg::ID_BITS;
  localparam int UF  = rbnh_pkg::UNIT_FRAC;
  localparam int DW  = rbnh_pkg::DIFF_W;
  localparam int LW  = rbnh_pkg::LEN_W;
  localparam int TW  = rbnh_pkg::T_W;
  localparam int UW  = rbnh_pkg::UNIT_W;
  localparam int IW  = rbnh_pkg::INV_W;
  localparam int IL  = (IW + 1) / 2;   // inverse split into two partial products
  localparam int IH  = IW - IL;
  localparam int PLW = DW + IL;
  localparam int PHW = DW + IH;
  localparam int PW  = DW + IW;
  localparam int PPW = UW + LW;
  localparam int NST = 7;

  localparam logic [LW-1:0]        TSAT  = {LW{1'b1}};
  localparam logic signed [TW:0]   PT_HI = {{(TW - CB + 2){1'b0}}, {(CB - 1){1'b1}}};
  localparam logic signed [TW:0]   PT_LO = {{(TW - CB + 2){1'b1}}, {(CB - 1){1'b0}}};

  typedef struct packed {
    logic [IDB-1:0] id;
    logic           elig;
    logic           last;
  } box_ctl_t;

  // ---------------- configuration registers ----------------
  logic [2:0][CB-1:0] cfg_start_q, cfg_end_q;
  logic               cfg_hit;

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_idx_i)
      rbnh_pkg::CFG_START_X, rbnh_pkg::CFG_START_Y, rbnh_pkg::CFG_START_Z,
      rbnh_pkg::CFG_END_X, rbnh_pkg::CFG_END_Y, rbnh_pkg::CFG_END_Z: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q <= '0;
      cfg_end_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbnh_pkg::CFG_START_X: cfg_start_q[0] <= cfg_wdata_i;
        rbnh_pkg::CFG_START_Y: cfg_start_q[1] <= cfg_wdata_i;
        rbnh_pkg::CFG_START_Z: cfg_start_q[2] <= cfg_wdata_i;
        rbnh_pkg::CFG_END_X:   cfg_end_q[0]   <= cfg_wdata_i;
        rbnh_pkg::CFG_END_Y:   cfg_end_q[1]   <= cfg_wdata_i;
        rbnh_pkg::CFG_END_Z:   cfg_end_q[2]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- setup sequencer, reruns after every register write ----------------
  rbnh_pkg::setup_t setup_res;
  logic             setup_done;

  rbnh_setup u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i && cfg_hit),
    .start_i   (cfg_start_q),
    .end_i     (cfg_end_q),
    .done_o    (setup_done),
    .res_o     (setup_res)
  );

  // ---------------- query control ----------------
  logic [NST-1:0] vld_q;
  logic           active_q;
  logic           pipe_en, accept, qstart;
  logic           out_valid_q;
  box_ctl_t       ctl_q [NST];

  // the only stall: a last item at the final stage with the output register still full
  assign pipe_en    = !(vld_q[NST-1] && ctl_q[NST-1].last && out_valid_q && !out_ready_i);
  assign in_ready_o = pipe_en && (active_q || ((vld_q == '0) && setup_done));
  assign accept     = in_valid_i && in_ready_o;
  assign qstart     = accept && !active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (accept) active_q <= !last_box_i;
      if (pipe_en) vld_q <= {vld_q[NST-2:0], accept};
    end
  end

  // ray context held for the running query; the pipeline is empty when it loads
  rbnh_pkg::setup_t   ctx_q;
  logic [2:0][CB-1:0] ctx_start_q;

  always_ff @(posedge clk_i) begin
    if (qstart) begin
      ctx_q       <= setup_res;
      ctx_start_q <= cfg_start_q;
    end
  end

  // item control travels along the pipeline
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ctl_q[0] <= '{id: box_id_i, elig: eligible_i, last: last_box_i};
      for (int k = 1; k < NST; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // ---------------- stage 0: input register ----------------
  logic [2:0][CB-1:0] s0_min_q, s0_max_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_min_q <= {box_min_z_i, box_min_y_i, box_min_x_i};
      s0_max_q <= {box_max_z_i, box_max_y_i, box_max_x_i};
    end
  end

  // ---------------- stage 1: offsets from the ray start ----------------
  logic signed [DW-1:0] d_min [3], d_max [3];
  logic [DW-1:0]        s1_mag_q [6];
  logic [5:0]           s1_neg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_min[i] = $signed({s0_min_q[i][CB-1], s0_min_q[i]})
               - $signed({ctx_start_q[i][CB-1], ctx_start_q[i]});
      d_max[i] = $signed({s0_max_q[i][CB-1], s0_max_q[i]})
               - $signed({ctx_start_q[i][CB-1], ctx_start_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_q[i]   <= d_min[i][DW-1] ? DW'(-d_min[i]) : DW'(d_min[i]);
        s1_mag_q[i+3] <= d_max[i][DW-1] ? DW'(-d_max[i]) : DW'(d_max[i]);
        s1_neg_q[i]   <= d_min[i][DW-1] ^ ctx_q.inv_neg[i];
        s1_neg_q[i+3] <= d_max[i][DW-1] ^ ctx_q.inv_neg[i];
      end
    end
  end

  // ---------------- stage 2: partial products against the inverse ----------------
  logic [PLW-1:0] s2_pl_q [6];
  logic [PHW-1:0] s2_ph_q [6];
  logic [5:0]     s2_neg_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_neg_q <= s1_neg_q;
      for (int i = 0; i < 3; i++) begin
        s2_pl_q[i]   <= {{IL{1'b0}}, s1_mag_q[i]} * {{DW{1'b0}}, ctx_q.inv_mag[i][IL-1:0]};
        s2_pl_q[i+3] <= {{IL{1'b0}}, s1_mag_q[i+3]} * {{DW{1'b0}}, ctx_q.inv_mag[i][IL-1:0]};
        s2_ph_q[i]   <= {{IH{1'b0}}, s1_mag_q[i]} * {{DW{1'b0}}, ctx_q.inv_mag[i][IW-1:IL]};
        s2_ph_q[i+3] <= {{IH{1'b0}}, s1_mag_q[i+3]} * {{DW{1'b0}}, ctx_q.inv_mag[i][IW-1:IL]};
      end
    end
  end

  // ---------------- stage 3: combine, scale, saturate, sign ----------------
  logic signed [TW-1:0] s3_t_d [6], s3_t_q [6];

  always_comb begin
    logic [PW-1:0]    p;
    logic [PW-FB-1:0] qf;
    logic [LW-1:0]    mg;
    for (int j = 0; j < 6; j++) begin
      p  = PW'(s2_pl_q[j]) + (PW'(s2_ph_q[j]) << IL);
      qf = p[PW-1:FB];
      mg = (qf > (PW-FB)'(TSAT)) ? TSAT : qf[LW-1:0];
      s3_t_d[j] = s2_neg_q[j] ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) s3_t_q <= s3_t_d;
  end

  // ---------------- stage 4: slab test and entry face ----------------
  logic [LW-1:0]   s4_tn_d, s4_tn_q;
  rbnh_pkg::axis_e s4_axis_d, s4_axis_q;
  logic            s4_cand_d, s4_cand_q;

  always_comb begin
    logic signed [TW-1:0] a [3];
    logic signed [TW-1:0] b [3];
    logic signed [TW-1:0] tn1, tf1, tn2, tf2, tnc;
    logic                 rej;
    for (int i = 0; i < 3; i++) begin
      a[i] = (s3_t_q[i] > s3_t_q[i+3]) ? s3_t_q[i+3] : s3_t_q[i];
      b[i] = (s3_t_q[i] > s3_t_q[i+3]) ? s3_t_q[i] : s3_t_q[i+3];
    end
    tn1 = (a[1] > a[0]) ? a[1] : a[0];
    tf1 = (b[1] < b[0]) ? b[1] : b[0];
    tn2 = (a[2] > tn1) ? a[2] : tn1;
    tf2 = (b[2] < tf1) ? b[2] : tf1;
    rej = (a[0] > b[1]) || (a[1] > b[0]) || (tn1 > b[2]) || (a[2] > tf1) || (tf2 < 0);
    tnc = (tn2 < 0) ? '0 : tn2;
    s4_tn_d   = tnc[LW-1:0];
    s4_cand_d = ctl_q[3].elig && ctx_q.seg_ok && !rej;
    // z wins a tie, then y
    priority if (tnc == a[2]) s4_axis_d = rbnh_pkg::AXIS_Z;
    else if (tnc == a[1])     s4_axis_d = rbnh_pkg::AXIS_Y;
    else                      s4_axis_d = rbnh_pkg::AXIS_X;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_tn_q   <= s4_tn_d;
      s4_axis_q <= s4_axis_d;
      s4_cand_q <= s4_cand_d;
    end
  end

  // ---------------- stage 5: hit point products ----------------
  logic [PPW-1:0]  s5_pp_q [3];
  logic [LW-1:0]   s5_tn_q;
  rbnh_pkg::axis_e s5_axis_q;
  logic            s5_cand_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        s5_pp_q[i] <= {{LW{1'b0}}, ctx_q.unit_mag[i]} * {{UW{1'b0}}, s4_tn_q};
      end
      s5_tn_q   <= s4_tn_q;
      s5_axis_q <= s4_axis_q;
      s5_cand_q <= s4_cand_q;
    end
  end

  // ---------------- stage 6: hit point and normal sign ----------------
  logic [2:0][CB-1:0] s6_pt_d, s6_pt_q;
  logic               s6_nneg_d, s6_nneg_q;
  logic [LW-1:0]      s6_tn_q;
  rbnh_pkg::axis_e    s6_axis_q;
  logic               s6_cand_q;

  always_comb begin
    logic [LW:0]          qq;
    logic [LW-1:0]        mg;
    logic signed [TW-1:0] v;
    logic signed [TW:0]   sum;
    for (int i = 0; i < 3; i++) begin
      qq  = s5_pp_q[i][PPW-1:UF];
      mg  = (qq > {1'b0, TSAT}) ? TSAT : qq[LW-1:0];
      v   = ctx_q.unit_neg[i] ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
      sum = $signed({{(TW - CB + 1){ctx_start_q[i][CB-1]}}, ctx_start_q[i]})
          + $signed({v[TW-1], v});
      priority if (sum > PT_HI) s6_pt_d[i] = PT_HI[CB-1:0];
      else if (sum < PT_LO)     s6_pt_d[i] = PT_LO[CB-1:0];
      else                      s6_pt_d[i] = sum[CB-1:0];
    end
    // normal points back along the ray: negative when the direction is positive
    unique case (s5_axis_q)
      rbnh_pkg::AXIS_X: s6_nneg_d = (ctx_q.unit_mag[0] != '0) && !ctx_q.unit_neg[0];
      rbnh_pkg::AXIS_Y: s6_nneg_d = (ctx_q.unit_mag[1] != '0) && !ctx_q.unit_neg[1];
      rbnh_pkg::AXIS_Z: s6_nneg_d = (ctx_q.unit_mag[2] != '0) && !ctx_q.unit_neg[2];
      default:          s6_nneg_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s6_pt_q   <= s6_pt_d;
      s6_nneg_q <= s6_nneg_d;
      s6_tn_q   <= s5_tn_q;
      s6_axis_q <= s5_axis_q;
      s6_cand_q <= s5_cand_q;
    end
  end

  // ---------------- nearest-hit tracking and result register ----------------
  logic [LW-1:0]      closest_q, closest_d;
  logic               any_hit_q, any_hit_d;
  logic [IDB-1:0]     best_id_q, best_id_d;
  rbnh_pkg::axis_e    best_axis_q, best_axis_d;
  logic               best_nneg_q, best_nneg_d;
  logic [2:0][CB-1:0] best_pt_q, best_pt_d;
  logic               upd, emit;

  // strictly nearer than the closest so far
  assign upd  = vld_q[NST-1] && s6_cand_q && (s6_tn_q < closest_q);
  assign emit = pipe_en && vld_q[NST-1] && ctl_q[NST-1].last;

  always_comb begin
    closest_d   = upd ? s6_tn_q : closest_q;
    any_hit_d   = any_hit_q || upd;
    best_id_d   = upd ? ctl_q[NST-1].id : best_id_q;
    best_axis_d = upd ? s6_axis_q : best_axis_q;
    best_nneg_d = upd ? s6_nneg_q : best_nneg_q;
    best_pt_d   = upd ? s6_pt_q : best_pt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closest_q   <= '0;
      any_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (qstart) begin
        closest_q <= LW'(setup_res.len);
        any_hit_q <= 1'b0;
      end else if (pipe_en) begin
        closest_q <= closest_d;
        any_hit_q <= any_hit_d;
      end
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && upd) begin
      best_id_q   <= best_id_d;
      best_axis_q <= best_axis_d;
      best_nneg_q <= best_nneg_d;
      best_pt_q   <= best_pt_d;
    end
    if (emit) begin
      hit_found_o       <= any_hit_d;
      hit_distance_o    <= any_hit_d ? closest_d[CB:0] : '0;
      hit_box_id_o      <= any_hit_d ? best_id_d : '0;
      normal_axis_o     <= any_hit_d ? best_axis_d : rbnh_pkg::AXIS_X;
      normal_negative_o <= any_hit_d && best_nneg_d;
      hit_point_x_o     <= any_hit_d ? best_pt_d[0] : '0;
      hit_point_y_o     <= any_hit_d ? best_pt_d[1] : '0;
      hit_point_z_o     <= any_hit_d ? best_pt_d[2] : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/rbnh_checker.sv
// port-level checks for the ray / box nearest-hit block, bound to the top level
module rbnh_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic                                   hit_found_o,
  input logic [rbnh_pkg::COORD_BITS:0]          hit_distance_o,
  input logic [rbnh_pkg::ID_BITS-1:0]           hit_box_id_o,
  input logic [1:0]                             normal_axis_o,
  input logic                                   normal_negative_o,
  input logic signed [rbnh_pkg::COORD_BITS-1:0] hit_point_x_o,
  input logic signed [rbnh_pkg::COORD_BITS-1:0] hit_point_y_o,
  input logic signed [rbnh_pkg::COORD_BITS-1:0] hit_point_z_o
);

  // a waiting result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // and keeps its distance and box id
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hit_distance_o) && $stable(hit_box_id_o))
    else $error("result item changed while stalled");

  // a miss reports all fields zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_found_o |-> hit_distance_o == '0 && hit_box_id_o == '0 &&
      normal_axis_o == rbnh_pkg::AXIS_X && !normal_negative_o &&
      hit_point_x_o == '0 && hit_point_y_o == '0 && hit_point_z_o == '0)
    else $error("miss with nonzero fields");

  // a hit names a real face axis
  a_hit_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_found_o |-> normal_axis_o == rbnh_pkg::AXIS_X ||
      normal_axis_o == rbnh_pkg::AXIS_Y || normal_axis_o == rbnh_pkg::AXIS_Z)
    else $error("hit with bad face axis");

endmodule

bind ray_box_nearest_hit rbnh_checker u_rbnh_checker (.*);

### dv/ray_box_nearest_hit_test.sv
// self-checking testbench for the ray / box nearest-hit block
`timescale 1ns / 1ps

module ray_box_nearest_hit_test;
  import rbnh_pkg::*;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint DIST_SAT = (64'sd1 <<< (COORD_BITS + 2)) - 1;
  localparam longint INV_SAT = (64'sd1 <<< (UNIT_FRAC + FRAC_BITS + 1)) - 1;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] lo;
    logic [2:0][COORD_BITS-1:0] hi;
    logic [ID_BITS-1:0] id;
    logic elig;
    logic last;
  } box_t;

  typedef struct packed {
    logic hit;
    logic [COORD_BITS:0] distance;
    logic [ID_BITS-1:0] id;
    axis_e axis;
    logic neg;
    logic [2:0][COORD_BITS-1:0] pt;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_START_X;
  logic [COORD_BITS-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [COORD_BITS-1:0] box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  logic signed [COORD_BITS-1:0] box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic [ID_BITS-1:0] box_id_i = '0;
  logic eligible_i = 1'b0;
  logic last_box_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_found_o;
  logic [COORD_BITS:0] hit_distance_o;
  logic [ID_BITS-1:0] hit_box_id_o;
  logic [1:0] normal_axis_o;
  logic normal_negative_o;
  logic signed [COORD_BITS-1:0] hit_point_x_o, hit_point_y_o, hit_point_z_o;

  ray_box_nearest_hit u_dut (.*);

  // stimulus and expectation stores
  box_t box_queue[$];
  hit_t nearest_hits[$];
  box_t box_on_bus;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;

  // ray registers as last written, and the per-query latched context
  longint ray_from[3], ray_to[3];
  longint q_org[3], unit_dir[3], inv_dir[3], best_pt[3];
  longint closest;
  logic q_active = 1'b0, seg_valid = 1'b0, any_hit = 1'b0;
  logic [ID_BITS-1:0] best_id;
  axis_e best_axis;
  logic best_neg;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("ray_box_nearest_hit regression: fail");
    $finish;
  end

  function automatic logic [127:0] magnitude(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // (a * b) >> sh on magnitudes, saturated, sign reapplied
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic [127:0] p;
    p = (magnitude(a) * magnitude(b)) >> sh;
    if (p > 128'(DIST_SAT)) p = 128'(DIST_SAT);
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint root_floor(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return longint'(r);
  endfunction

  function automatic longint sx(logic [COORD_BITS-1:0] v);
    return longint'($signed(v));
  endfunction

  task automatic open_query();
    logic [127:0] sq_sum, q;
    longint mv, seg_len;
    sq_sum = '0;
    for (int i = 0; i < 3; i++) begin
      q_org[i] = ray_from[i];
      mv = ray_to[i] - ray_from[i];
      sq_sum += magnitude(mv) * magnitude(mv);
    end
    seg_valid = (sq_sum != 0);
    seg_len = root_floor(sq_sum);
    for (int i = 0; i < 3; i++) begin
      mv = ray_to[i] - ray_from[i];
      q = (seg_len != 0) ? (magnitude(mv) << UNIT_FRAC) / 128'(seg_len) : '0;
      unit_dir[i] = (mv < 0) ? -longint'(q) : longint'(q);
      if (q == 0) inv_dir[i] = INV_SAT;
      else begin
        inv_dir[i] = longint'((128'd1 << (UNIT_FRAC + FRAC_BITS)) / q);
        if (mv < 0) inv_dir[i] = -inv_dir[i];
      end
      best_pt[i] = 0;
    end
    closest = seg_len;
    any_hit = 1'b0;
    best_id = '0;
    best_axis = AXIS_X;
    best_neg = 1'b0;
    q_active = 1'b1;
  endtask

  // slab test of one eligible box against the latched ray
  task automatic slab_test(box_t b);
    longint t0[3], t1[3], ta, tb, tn, tf, p;
    axis_e ax;
    for (int i = 0; i < 3; i++) begin
      ta = scaled_product(sx(b.lo[i]) - q_org[i], inv_dir[i], FRAC_BITS);
      tb = scaled_product(sx(b.hi[i]) - q_org[i], inv_dir[i], FRAC_BITS);
      t0[i] = (ta > tb) ? tb : ta;
      t1[i] = (ta > tb) ? ta : tb;
    end
    if (t0[0] > t1[1] || t0[1] > t1[0]) return;
    tn = (t0[1] > t0[0]) ? t0[1] : t0[0];
    tf = (t1[1] < t1[0]) ? t1[1] : t1[0];
    if (tn > t1[2] || t0[2] > tf) return;
    if (t0[2] > tn) tn = t0[2];
    if (t1[2] < tf) tf = t1[2];
    // box entirely behind the start
    if (tf < 0) return;
    if (tn < 0) tn = 0;
    // only strictly nearer hits replace the best one
    if (tn >= closest) return;
    closest = tn;
    any_hit = 1'b1;
    best_id = b.id;
    ax = (tn == t0[2]) ? AXIS_Z : (tn == t0[1]) ? AXIS_Y : AXIS_X;
    best_axis = ax;
    best_neg = (unit_dir[ax] > 0);
    for (int i = 0; i < 3; i++) begin
      p = q_org[i] + scaled_product(unit_dir[i], tn, UNIT_FRAC);
      best_pt[i] = (p > COORD_MAX) ? COORD_MAX : (p < COORD_MIN) ? COORD_MIN : p;
    end
  endtask

  task automatic predict_box(box_t b);
    hit_t h;
    if (!q_active) open_query();
    if (b.elig && seg_valid) slab_test(b);
    if (b.last) begin
      h = '0;
      if (any_hit) begin
        h.hit = 1'b1;
        h.distance = closest[COORD_BITS:0];
        h.id = best_id;
        h.axis = best_axis;
        h.neg = best_neg;
        for (int i = 0; i < 3; i++) h.pt[i] = best_pt[i][COORD_BITS-1:0];
      end
      nearest_hits.insert(nearest_hits.size(), h);
      q_active = 1'b0;
    end
  endtask

  // box driver: takes the next item when the bus is free or the current one was taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_box(box_on_bus);
      if (!in_valid_i || in_ready_o) begin
        if (box_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          box_on_bus = box_queue.pop_front();
          in_valid_i <= 1'b1;
          box_min_x_i <= box_on_bus.lo[0];
          box_min_y_i <= box_on_bus.lo[1];
          box_min_z_i <= box_on_bus.lo[2];
          box_max_x_i <= box_on_bus.hi[0];
          box_max_y_i <= box_on_bus.hi[1];
          box_max_z_i <= box_on_bus.hi[2];
          box_id_i <= box_on_bus.id;
          eligible_i <= box_on_bus.elig;
          last_box_i <= box_on_bus.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generator, with an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    hit_t exp_h, got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '0;
        got.hit = hit_found_o;
        got.distance = hit_distance_o;
        got.id = hit_box_id_o;
        got.axis = axis_e'(normal_axis_o);
        got.neg = normal_negative_o;
        got.pt[0] = hit_point_x_o;
        got.pt[1] = hit_point_y_o;
        got.pt[2] = hit_point_z_o;
        if (nearest_hits.size() == 0) begin
          errors++;
          $display("%0t result exp none got %p", $time, got);
        end else begin
          exp_h = nearest_hits.pop_front();
          if (got.hit !== exp_h.hit)
            $display("%0t hit_found exp %0d got %0d", $time, exp_h.hit, got.hit);
          if (got.distance !== exp_h.distance)
            $display("%0t hit_distance exp %0h got %0h", $time, exp_h.distance,
                     got.distance);
          if (got.id !== exp_h.id)
            $display("%0t hit_box_id exp %0h got %0h", $time, exp_h.id, got.id);
          if (got.axis !== exp_h.axis)
            $display("%0t normal_axis exp %0d got %0d", $time, exp_h.axis, got.axis);
          if (got.neg !== exp_h.neg)
            $display("%0t normal_negative exp %0d got %0d", $time, exp_h.neg, got.neg);
          for (int i = 0; i < 3; i++)
            if (got.pt[i] !== exp_h.pt[i])
              $display("%0t hit_point[%0d] exp %0h got %0h", $time, i, exp_h.pt[i],
                       got.pt[i]);
          if (got !== exp_h) errors++;
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] clip(longint v);
    longint c;
    c = (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
    return c[COORD_BITS-1:0];
  endfunction

  task automatic add_box(longint lx, longint ly, longint lz, longint hx, longint hy,
                         longint hz, int id, bit elig, bit last);
    box_t b;
    b.lo[0] = clip(lx); b.lo[1] = clip(ly); b.lo[2] = clip(lz);
    b.hi[0] = clip(hx); b.hi[1] = clip(hy); b.hi[2] = clip(hz);
    b.id = id[ID_BITS-1:0];
    b.elig = elig;
    b.last = last;
    box_queue.insert(box_queue.size(), b);
  endtask

  // box around a point on (or a bit past) the segment, or an arbitrary box
  task automatic add_random_box(bit last);
    longint c[3], half[3];
    int k;
    if ($urandom_range(99) < 80) begin
      k = $urandom_range(1300);
      for (int i = 0; i < 3; i++) begin
        c[i] = ray_from[i] + ((ray_to[i] - ray_from[i]) * k) / 1024
               + longint'($signed($urandom)) / (longint'(1) << $urandom_range(31, 12));
        half[i] = ($urandom_range(9) == 0) ? longint'($urandom)
                                           : longint'($urandom_range(1 << 19, 1));
      end
      add_box(c[0] - half[0], c[1] - half[1], c[2] - half[2],
              c[0] + half[0], c[1] + half[1], c[2] + half[2],
              $urandom, $urandom_range(99) < 85, last);
    end else begin
      add_box(sx($urandom), sx($urandom), sx($urandom), sx($urandom), sx($urandom),
              sx($urandom), $urandom, $urandom_range(1), last);
    end
  endtask

  task automatic add_random_queries(int n, int max_len);
    int len;
    while (n > 0) begin
      len = $urandom_range(max_len, 1);
      for (int j = 0; j < len; j++) add_random_box(j == len - 1);
      n -= len;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, longint v, output longint mirror);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= clip(v);
    mirror = sx(clip(v));
  endtask

  task automatic set_ray(longint sx0, longint sy0, longint sz0, longint ex, longint ey,
                         longint ez);
    write_reg(CFG_START_X, sx0, ray_from[0]);
    write_reg(CFG_START_Y, sy0, ray_from[1]);
    write_reg(CFG_START_Z, sz0, ray_from[2]);
    write_reg(CFG_END_X, ex, ray_to[0]);
    write_reg(CFG_END_Y, ey, ray_to[1]);
    write_reg(CFG_END_Z, ez, ray_to[2]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender pauses here until every expected result is back
  task automatic drain();
    while (box_queue.size() > 0 || in_valid_i || nearest_hits.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    longint u;
    u = longint'(1) << FRAC_BITS;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // zero-length segment: nothing can be hit
    set_ray(0, 0, 0, 0, 0, 0);
    add_box(-u, -u, -u, u, u, u, 16'h0001, 1, 0);
    add_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 16'hffff, 1, 1);
    drain();

    // diagonal ray, directed cases
    set_ray(-10 * u, -10 * u, -10 * u, 10 * u, 10 * u, 10 * u);
    add_box(-u, -u, -u, u, u, u, 16'h0011, 1, 0);
    add_box(-3 * u, -3 * u, -3 * u, -2 * u, -2 * u, -2 * u, 16'h0012, 1, 0);
    add_box(-3 * u, -3 * u, -3 * u, -2 * u, -2 * u, -2 * u, 16'h0013, 1, 1);  // tie
    add_box(-6 * u, -6 * u, -6 * u, -5 * u, -5 * u, -5 * u, 16'h0021, 0, 0);  // ineligible
    add_box(-20 * u, -20 * u, -20 * u, -15 * u, -15 * u, -15 * u, 16'h0022, 1, 0); // behind
    add_box(15 * u, 15 * u, 15 * u, 20 * u, 20 * u, 20 * u, 16'h0023, 1, 1);  // past end
    add_box(-11 * u, -11 * u, -11 * u, 0, 0, 0, 16'h0031, 1, 1);  // start inside
    add_box(u, u, u, -u, -u, -u, 16'h0041, 1, 1);                 // swapped corners
    add_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 16'hffff, 1, 1);
    add_box(5 * u, -u, -u, 6 * u, u, u, 16'h0000, 1, 1);          // miss
    add_box(-4 * u, -9 * u, -9 * u, 9 * u, 9 * u, 9 * u, 16'h8000, 1, 1);
    add_box(-9 * u, -9 * u, -4 * u, 9 * u, 9 * u, 9 * u, 16'h7fff, 1, 1);
    add_random_queries(110, 6);
    drain();

    // x-only ray: zero direction components, sender idle
    send_idle_pct = 62;
    set_ray(-5 * u, 0, u, 7 * u, 0, u);
    add_box(-u, -u, 0, u, u, 2 * u, 16'h0101, 1, 1);
    add_box(-u, u, 0, u, 2 * u, 2 * u, 16'h0102, 1, 1);
    add_random_queries(110, 6);
    drain();

    // full-range segment, receiver stalling
    send_idle_pct = 0;
    recv_stall_pct = 62;
    set_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    add_random_queries(120, 6);
    drain();

    // random ray, both sides idling
    send_idle_pct = 33;
    recv_stall_pct = 33;
    set_ray(sx($urandom), sx($urandom), sx($urandom), sx($urandom), sx($urandom),
            sx($urandom));
    add_random_queries(120, 6);
    drain();

    // short queries under a long receiver hold-off so the block backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_ray(sx($urandom) >>> 12, sx($urandom) >>> 12, sx($urandom) >>> 12,
            sx($urandom) >>> 12, sx($urandom) >>> 12, sx($urandom) >>> 12);
    add_random_queries(80, 2);
    hold_reqs++;
    drain();

    // reversed full-range segment, mixed idling
    send_idle_pct = 33;
    recv_stall_pct = 62;
    set_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
    add_random_queries(95, 6);
    drain();

    if (errors == 0) begin
      $display("ray_box_nearest_hit regression: pass");
    end else begin
      $display("ray_box_nearest_hit regression: fail");
    end
    $finish;
  end

endmodule
